// ----- design/merkle_inclusion_verify_macros.svh -----
// Assertion macros shared by the merkle inclusion verifier modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MERKLE_INCLUSION_VERIFY_MACROS_SVH
`define MERKLE_INCLUSION_VERIFY_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MIV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MIV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/miv_pkg.sv -----
// Package for the merkle inclusion verifier: SHA-256 constants, types, functions.
// Depends on nothing; used by every module of the block.
package miv_pkg;

  localparam int unsigned RoundN = 64;
  localparam int unsigned RoundW = 6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // register the accepted input item
    logic init_blk0;    // load IV and first message block
    logic init_blk1;    // load second message block, keep chaining value
    logic round;        // run one compression round
    logic fold;         // add working vars into chaining value
    logic commit;       // copy digest into accumulator
    logic skip;         // path step with no leaf
    logic emit;         // load result register, clear proof state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_step;
    logic two_blocks;
    logic last;
    logic leaf_loaded;
  } sts_t;

  function automatic logic [31:0] round_k(input logic [RoundW-1:0] i);
    logic [31:0] k [RoundN];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  localparam logic [255:0] Iv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- design/miv_ctrl.sv -----
// Controller state machine for the merkle inclusion verifier.
// Depends on miv_pkg and the assertion macro header.
`include "merkle_inclusion_verify_macros.svh"

module miv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  input  miv_pkg::sts_t      sts,
  output miv_pkg::cmd_t      cmd
);

  miv_pkg::state_t state, state_next;
  logic [miv_pkg::RoundW-1:0] rnd, rnd_next;
  logic blk, blk_next;

  // State, round counter and block index.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= miv_pkg::ST_IDLE;
      rnd <= '0;
      blk <= 1'b0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      blk <= blk_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    rnd_next = rnd;
    blk_next = blk;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      miv_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = miv_pkg::ST_START;
        end
      end
      miv_pkg::ST_START: begin
        if (sts.is_step && !sts.leaf_loaded) begin
          cmd.skip = 1'b1;
          state_next = sts.last ? miv_pkg::ST_OUT : miv_pkg::ST_IDLE;
          if (sts.last) cmd.emit = 1'b1;
        end else begin
          cmd.init_blk0 = 1'b1;
          rnd_next = '0;
          blk_next = 1'b0;
          state_next = miv_pkg::ST_ROUND;
        end
      end
      miv_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next = rnd + 1'b1;
        if (rnd == miv_pkg::RoundW'(miv_pkg::RoundN - 1)) state_next = miv_pkg::ST_FOLD;
      end
      miv_pkg::ST_FOLD: begin
        if (sts.two_blocks && !blk) begin
          cmd.fold = 1'b1;
          blk_next = 1'b1;
          state_next = miv_pkg::ST_ROUND;
        end else begin
          cmd.commit = 1'b1;
          if (sts.last) begin
            cmd.emit = 1'b1;
            state_next = miv_pkg::ST_OUT;
          end else begin
            state_next = miv_pkg::ST_IDLE;
          end
        end
        if (sts.two_blocks && !blk) cmd.init_blk1 = 1'b1;
      end
      miv_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_stall = 1'b1;
        if (!out_stall) state_next = miv_pkg::ST_IDLE;
      end
      default: state_next = miv_pkg::ST_IDLE;
    endcase
  end

  `MIV_ASSERT_IMP(a_rnd_zero_idle, clk, rst, state == miv_pkg::ST_IDLE, rnd == '0)
  `MIV_ASSERT_NEXT(a_fold_after_rounds, clk, rst,
    state == miv_pkg::ST_ROUND && rnd == miv_pkg::RoundW'(miv_pkg::RoundN - 1),
    state == miv_pkg::ST_FOLD)
  `MIV_ASSERT_IMP(a_no_accept_busy, clk, rst, state != miv_pkg::ST_IDLE, in_stall)

endmodule

// ----- design/miv_dp.sv -----
// Datapath for the merkle inclusion verifier: message schedule, SHA-256 round,
// accumulator, counters and result register. Depends on miv_pkg.
module miv_dp (
  input  logic        clk,
  input  logic        rst,
  input  miv_pkg::cmd_t cmd,
  output miv_pkg::sts_t sts,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        op,
  input  logic        sibling_right,
  input  logic [63:0] data_w0,
  input  logic [63:0] data_w1,
  input  logic [63:0] data_w2,
  input  logic [63:0] data_w3,
  input  logic        last,
  output logic        match,
  output logic [7:0]  step_count,
  output logic        order_error,
  output logic [63:0] computed_w0,
  output logic [63:0] computed_w1,
  output logic [63:0] computed_w2,
  output logic [63:0] computed_w3
);

  logic [255:0] root, acc, dat, hv;
  logic [31:0]  wv [8];
  logic [31:0]  w [16];
  logic r_op, r_right, r_last, leaf_loaded, error_seen;
  logic [7:0] steps_done;
  logic [miv_pkg::RoundW-1:0] rcnt;
  logic [519:0] node_msg;
  logic [511:0] blk0, blk0_leaf, blk0_node, blk1_node;

  // Configuration writes to the expected root.
  always_ff @(posedge clk) begin
    if (rst) root <= '0;
    else if (cfg_we) root[255 - 64*cfg_idx -: 64] <= cfg_data;
  end

  // Message blocks: the 33-byte leaf message is one block, the 65-byte node
  // message spills its last byte into a second block with the length.
  assign node_msg = r_right ? {8'h01, acc, dat} : {8'h01, dat, acc};
  assign blk0_leaf = {8'h00, dat, 8'h80, 176'd0, 64'd264};
  assign blk0_node = node_msg[519:8];
  assign blk1_node = {node_msg[7:0], 8'h80, 432'd0, 64'd520};
  assign blk0 = r_op ? blk0_node : blk0_leaf;

  // Round logic.
  logic [31:0] t1, t2, s0, s1, wn, kk;
  always_comb begin
    kk = miv_pkg::round_k(rcnt);
    t1 = wv[7] + (miv_pkg::rotr(wv[4], 6) ^ miv_pkg::rotr(wv[4], 11) ^ miv_pkg::rotr(wv[4], 25))
       + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + kk + w[0];
    t2 = (miv_pkg::rotr(wv[0], 2) ^ miv_pkg::rotr(wv[0], 13) ^ miv_pkg::rotr(wv[0], 22))
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    s0 = miv_pkg::rotr(w[1], 7) ^ miv_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = miv_pkg::rotr(w[14], 17) ^ miv_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
  end

  // Working registers, schedule window and captured input item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_op <= op; r_right <= sibling_right; r_last <= last;
      dat <= {data_w0, data_w1, data_w2, data_w3};
    end
    if (cmd.init_blk0 || cmd.init_blk1) begin
      logic [255:0] base;
      logic [511:0] b;
      base = cmd.init_blk0 ? miv_pkg::Iv : hv;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) base[255-32*i -: 32] = hv[255-32*i -: 32] + wv[i];
      end
      b = cmd.init_blk0 ? blk0 : blk1_node;
      hv <= base;
      for (int i = 0; i < 8; i++) wv[i] <= base[255-32*i -: 32];
      for (int i = 0; i < 16; i++) w[i] <= b[511-32*i -: 32];
      rcnt <= '0;
    end else if (cmd.round) begin
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      rcnt <= rcnt + 1'b1;
    end
  end

  // Digest folding and proof state.
  logic [255:0] dig;
  always_comb begin
    for (int i = 0; i < 8; i++) dig[255-32*i -: 32] = hv[255-32*i -: 32] + wv[i];
  end

  // The result clears the proof state, so a new proof starts clean.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0; leaf_loaded <= 1'b0; steps_done <= '0; error_seen <= 1'b0;
    end else if (cmd.emit) begin
      acc <= '0; leaf_loaded <= 1'b0; steps_done <= '0; error_seen <= 1'b0;
    end else if (cmd.commit) begin
      acc <= dig;
      if (!r_op) begin
        leaf_loaded <= 1'b1; steps_done <= '0; error_seen <= 1'b0;
      end else if (steps_done != 8'hff) begin
        steps_done <= steps_done + 1'b1;
      end
    end else if (cmd.skip) begin
      error_seen <= 1'b1;
    end
  end

  // Result register, loaded from the state as it stands after this item.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      logic [255:0] fa;
      logic [7:0] fs;
      logic fe;
      fa = cmd.commit ? dig : acc;
      fs = steps_done;
      fe = error_seen | cmd.skip;
      if (cmd.commit) begin
        if (!r_op) begin fs = '0; fe = 1'b0; end
        else if (steps_done != 8'hff) fs = steps_done + 1'b1;
      end
      match <= (fa == root);
      step_count <= fs;
      order_error <= fe;
      {computed_w0, computed_w1, computed_w2, computed_w3} <= fa;
    end
  end

  assign sts.is_step = r_op;
  assign sts.two_blocks = r_op;
  assign sts.last = r_last;
  assign sts.leaf_loaded = leaf_loaded;

endmodule

// ----- design/merkle_inclusion_verify.sv -----
// Merkle inclusion proof verifier (SHA-256, leaf tag 0x00, node tag 0x01).
// A leaf item takes one compression of 64 rounds plus load and fold, a path
// step takes two compressions sharing the single one-round-per-cycle SHA-256
// unit, and a step without a leaf is skipped without a compression.
// The result of an item marked last is held until taken; items are handled
// one at a time. Depends on miv_pkg, miv_ctrl and miv_dp.
module merkle_inclusion_verify (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic        sibling_right,
  input  logic [63:0] data_w0,
  input  logic [63:0] data_w1,
  input  logic [63:0] data_w2,
  input  logic [63:0] data_w3,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        match,
  output logic [7:0]  step_count,
  output logic        order_error,
  output logic [63:0] computed_w0,
  output logic [63:0] computed_w1,
  output logic [63:0] computed_w2,
  output logic [63:0] computed_w3
);

  miv_pkg::cmd_t cmd;
  miv_pkg::sts_t sts;

  miv_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_stall, .out_valid, .sts, .cmd
  );

  miv_dp u_dp (
    .clk, .rst, .cmd, .sts, .cfg_we, .cfg_idx, .cfg_data,
    .op, .sibling_right, .data_w0, .data_w1, .data_w2, .data_w3, .last,
    .match, .step_count, .order_error,
    .computed_w0, .computed_w1, .computed_w2, .computed_w3
  );

endmodule
